>>> rtl/lpe_pkg.sv
// Shared widths, register indexes, reset values and the lane weight table
// for the line position error estimator. No dependencies.
package lpe_pkg;

	localparam int SENSOR_LANES_DEF = 8;
	localparam int SENSOR_LANES_MAX = 16;
	localparam int LANE_IDX_W       = 4;

	localparam int INPUT_W = 8;
	localparam int ERR_W   = 16;
	localparam int MAG_W   = 15;
	localparam int SUM_W   = 8;
	localparam int CNT_W   = 4;
	localparam int FRAC_W  = 8;
	localparam int STEP_W  = 4;

	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LOST_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT_STEP     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT    = 2'd2;

	localparam logic [CFG_W-1:0] LOST_THRESHOLD_RST = 15'd512;
	localparam logic [CFG_W-1:0] DRIFT_STEP_RST     = 15'd128;
	localparam logic [CFG_W-1:0] ERROR_LIMIT_RST    = 15'd25600;

	function automatic logic signed [SUM_W-1:0] lane_weight(input logic [LANE_IDX_W-1:0] lane);
		logic signed [SUM_W-1:0] w;
		unique case (lane)
			4'd0:    w = 8'sd30;
			4'd1:    w = 8'sd20;
			4'd2:    w = 8'sd10;
			4'd3:    w = 8'sd5;
			4'd4:    w = -8'sd5;
			4'd5:    w = -8'sd10;
			4'd6:    w = -8'sd20;
			4'd7:    w = -8'sd30;
			default: w = 8'sd0;
		endcase
		return w;
	endfunction

endpackage

>>> rtl/lpe_in_if.sv
// Scan channel: one word of line detector bits with valid/ready.
// Depends on lpe_pkg.
interface lpe_in_if;
	logic                         valid;
	logic                         ready;
	logic [lpe_pkg::INPUT_W-1:0]  sensor_bits;

	modport source (output valid, output sensor_bits, input ready);
	modport sink   (input valid, input sensor_bits, output ready);
endinterface

>>> rtl/lpe_out_if.sv
// Result channel: signed Q8.8 position error and line found flag with valid/ready.
// Depends on lpe_pkg.
interface lpe_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [lpe_pkg::ERR_W-1:0]  position_error;
	logic                              line_found;

	modport source (output valid, output position_error, output line_found, input ready);
	modport sink   (input valid, input position_error, input line_found, output ready);
endinterface

>>> rtl/line_position_error_estimator.sv
// Line position error estimator: serial weighted centroid over the sensor lanes,
// bit-serial restoring divide, and held error drift when the line is lost.
// Depends on lpe_pkg, lpe_in_if, lpe_out_if.
//
//   channel  dir  payload                          transfer
//   scan     in   sensor_bits[7:0]                 valid & ready
//   result   out  position_error[15:0], line_found valid & ready
//   cfg      in   cfg_index[1:0], cfg_data[14:0]   cfg_we
//
// A word is accumulated one lane per cycle (ST_ACC) and checked (ST_CHK); when a line
// is seen, ST_DIV forms 15 quotient bits one per cycle, and when no sensor is lit,
// ST_DRIFT drifts the held error instead; ST_APPLY then writes the result.
// Reset clears the held error and loads the register defaults.
// A pending result does not block acceptance; the next result waits for it.
module line_position_error_estimator #(
	parameter int SENSOR_LANES = lpe_pkg::SENSOR_LANES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	lpe_in_if.sink                          scan,
	lpe_out_if.source                       result,
	input  logic                            cfg_we,
	input  logic [lpe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lpe_pkg::CFG_W-1:0]       cfg_data
);

	localparam int LANE_W = $clog2(SENSOR_LANES);
	localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(SENSOR_LANES - 1);
	localparam logic [lpe_pkg::STEP_W-1:0] LAST_STEP = lpe_pkg::STEP_W'(lpe_pkg::MAG_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_CHK,
		ST_DIV,
		ST_DRIFT,
		ST_APPLY
	} state_t;

	state_t                              state_q;
	logic [SENSOR_LANES-1:0]             lanes_q;
	logic [LANE_W-1:0]                   lane_q;
	logic signed [lpe_pkg::SUM_W-1:0]    sum_q;
	logic [lpe_pkg::CNT_W-1:0]           cnt_q;
	logic [lpe_pkg::MAG_W-1:0]           div_q;
	logic [lpe_pkg::CNT_W-1:0]           rem_q;
	logic [lpe_pkg::STEP_W-1:0]          step_q;
	logic [lpe_pkg::MAG_W-1:0]           mag_q;
	logic                                neg_q;
	logic                                found_q;
	logic signed [lpe_pkg::ERR_W-1:0]    held_q;
	logic                                out_valid_q;
	logic                                out_found_q;

	logic [lpe_pkg::CFG_W-1:0]           thr_q;
	logic [lpe_pkg::CFG_W-1:0]           dstep_q;
	logic [lpe_pkg::CFG_W-1:0]           limit_q;

	logic [SENSOR_LANES-1:0]             lanes_in;
	logic signed [lpe_pkg::SUM_W-1:0]    lane_w;
	logic [lpe_pkg::SUM_W-1:0]           abs_sum;
	logic [lpe_pkg::ERR_W-1:0]           abs_held;
	logic [lpe_pkg::CNT_W:0]             rem_sh;
	logic                                qbit;
	logic [lpe_pkg::CNT_W-1:0]           rem_next;
	logic [lpe_pkg::MAG_W-1:0]           div_next;
	logic [lpe_pkg::MAG_W:0]             grown;
	logic [lpe_pkg::MAG_W-1:0]           drift_mag;
	logic [lpe_pkg::ERR_W-1:0]           signed_mag;
	logic                                scan_acc;

	genvar gi;
	generate
		for (gi = 0; gi < SENSOR_LANES; gi++) begin : g_lane
			if (gi < lpe_pkg::INPUT_W) begin : g_used
				assign lanes_in[gi] = scan.sensor_bits[gi];
			end else begin : g_unused
				assign lanes_in[gi] = 1'b0;
			end
		end
	endgenerate

	assign scan.ready = (state_q == ST_IDLE);
	assign scan_acc   = scan.valid && scan.ready;

	assign result.valid          = out_valid_q;
	assign result.position_error = held_q;
	assign result.line_found     = out_found_q;

	assign lane_w   = lpe_pkg::lane_weight(lpe_pkg::LANE_IDX_W'(lane_q));
	assign abs_sum  = sum_q[lpe_pkg::SUM_W-1] ? lpe_pkg::SUM_W'(-sum_q) : sum_q;
	assign abs_held = held_q[lpe_pkg::ERR_W-1] ? lpe_pkg::ERR_W'(-held_q) : held_q;

	assign rem_sh   = {rem_q, div_q[lpe_pkg::MAG_W-1]};
	assign qbit     = (rem_sh >= {1'b0, cnt_q});
	assign rem_next = qbit ? lpe_pkg::CNT_W'(rem_sh - {1'b0, cnt_q})
	                       : lpe_pkg::CNT_W'(rem_sh);
	assign div_next = {div_q[lpe_pkg::MAG_W-2:0], qbit};

	assign grown = {1'b0, mag_q} + {1'b0, dstep_q};

	always_comb begin
		drift_mag = mag_q;
		if (mag_q > thr_q) begin
			if (grown > {1'b0, limit_q}) begin
				drift_mag = (mag_q > limit_q) ? mag_q : limit_q;
			end else begin
				drift_mag = grown[lpe_pkg::MAG_W-1:0];
			end
		end
	end

	assign signed_mag = neg_q ? lpe_pkg::ERR_W'(-{1'b0, mag_q}) : {1'b0, mag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= lpe_pkg::LOST_THRESHOLD_RST;
			dstep_q <= lpe_pkg::DRIFT_STEP_RST;
			limit_q <= lpe_pkg::ERROR_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lpe_pkg::REG_LOST_THRESHOLD: thr_q   <= cfg_data;
				lpe_pkg::REG_DRIFT_STEP:     dstep_q <= cfg_data;
				lpe_pkg::REG_ERROR_LIMIT:    limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			lanes_q     <= '0;
			lane_q      <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (out_valid_q && result.ready && state_q != ST_APPLY) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (scan_acc) begin
						lanes_q <= lanes_in;
						lane_q  <= '0;
						sum_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (lanes_q[0]) begin
						sum_q <= sum_q + lane_w;
						cnt_q <= cnt_q + 1'b1;
					end
					lanes_q <= lanes_q >> 1;
					lane_q  <= lane_q + 1'b1;
					if (lane_q == LAST_LANE) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					found_q <= (cnt_q != '0);
					if (cnt_q == '0) begin
						mag_q   <= abs_held[lpe_pkg::MAG_W-1:0];
						neg_q   <= held_q[lpe_pkg::ERR_W-1];
						state_q <= ST_DRIFT;
					end else begin
						div_q   <= {abs_sum[lpe_pkg::MAG_W-lpe_pkg::FRAC_W-1:0],
						            lpe_pkg::FRAC_W'(0)};
						rem_q   <= '0;
						step_q  <= '0;
						neg_q   <= sum_q[lpe_pkg::SUM_W-1];
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_q  <= div_next;
					rem_q  <= rem_next;
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						mag_q   <= div_next;
						state_q <= ST_APPLY;
					end
				end
				ST_DRIFT: begin
					mag_q   <= drift_mag;
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (!out_valid_q || result.ready) begin
						held_q      <= signed_mag;
						out_found_q <= found_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
